@@ hw/rtl/opfw_pkg.sv @@
// shared types, register codes and helpers for the oriented pixel format writer
// no dependencies; imported by the interfaces and every rtl module
package opfw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_DATA_W     = 18;
  localparam int CFG_INDEX_W    = 3;
  localparam int DIM_W          = 16;
  localparam int STRIDE_W       = 18;
  localparam int MAP_W          = 18;   // signed mapped coordinate, holds -131072..131071
  localparam int OFFSET_W       = 34;
  localparam int COL_OFF_W      = 18;   // mapped column times up to four bytes
  localparam int WORD_W         = 32;
  localparam int BYTES_W        = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_FORMAT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_KIND = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HONOUR      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SWAP        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE      = 3'd7;

  // output formats
  localparam logic [1:0] FMT_ARGB8888 = 2'd0;
  localparam logic [1:0] FMT_RGB565   = 2'd1;
  localparam logic [1:0] FMT_ALPHA8   = 2'd2;

  // source kinds
  localparam logic [2:0] KIND_GRAY     = 3'd4;
  localparam logic [2:0] KIND_GRAY_INV = 3'd5;
  localparam logic [2:0] KIND_RGB      = 3'd6;
  localparam logic [2:0] KIND_RGBA     = 3'd7;

  // orientation codes
  localparam logic [3:0] ORI_TOP_LEFT     = 4'd1;
  localparam logic [3:0] ORI_TOP_RIGHT    = 4'd2;
  localparam logic [3:0] ORI_BOTTOM_RIGHT = 4'd3;
  localparam logic [3:0] ORI_BOTTOM_LEFT  = 4'd4;
  localparam logic [3:0] ORI_LEFT_TOP     = 4'd5;
  localparam logic [3:0] ORI_RIGHT_TOP    = 4'd6;
  localparam logic [3:0] ORI_RIGHT_BOTTOM = 4'd7;
  localparam logic [3:0] ORI_LEFT_BOTTOM  = 4'd8;
  localparam logic [3:0] ORI_FLIP_FOLD    = 4'd4;

  // luminance weights
  localparam logic [7:0] LUM_R = 8'd77;
  localparam logic [7:0] LUM_G = 8'd150;
  localparam logic [7:0] LUM_B = 8'd29;
  localparam logic [7:0] SAMPLE_MAX = 8'hFF;

  // reset values
  localparam logic [1:0]          RST_OUT_FORMAT  = FMT_ARGB8888;
  localparam logic [2:0]          RST_SOURCE_KIND = KIND_RGB;
  localparam logic [3:0]          RST_ORIENTATION = ORI_TOP_LEFT;
  localparam logic [DIM_W-1:0]    RST_DIM         = 16'd1;
  localparam logic [STRIDE_W-1:0] RST_STRIDE      = 18'd4;

  typedef struct packed {
    logic [1:0]          out_format;
    logic [2:0]          source_kind;
    logic [3:0]          orientation;
    logic                honour;
    logic                swap;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  // stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
  } adv_t;

  function automatic logic [BYTES_W-1:0] fmt_bytes(input logic [1:0] fmt);
    logic [BYTES_W-1:0] n;
    case (fmt)
      FMT_RGB565: n = 3'd2;
      FMT_ALPHA8: n = 3'd1;
      default:    n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] fmt_shift(input logic [1:0] fmt);
    logic [1:0] s;
    case (fmt)
      FMT_RGB565: s = 2'd1;
      FMT_ALPHA8: s = 2'd0;
      default:    s = 2'd2;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/opfw_in_if.sv @@
// request channel carrying one source pixel and its logical coordinate
// depends on opfw_pkg
interface opfw_in_if
  import opfw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] line;
  logic [7:0]            byte0;
  logic [7:0]            byte1;
  logic [7:0]            byte2;
  logic [7:0]            byte3;
  logic [2:0]            bit_index;

  modport source (output valid, col, line, byte0, byte1, byte2, byte3, bit_index,
                  input ready);
  modport sink   (input valid, col, line, byte0, byte1, byte2, byte3, bit_index,
                  output ready);
endinterface

@@ hw/rtl/opfw_out_if.sv @@
// result channel carrying the packed pixel, its byte offset and write flag
// depends on opfw_pkg
interface opfw_out_if
  import opfw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                write_enable;
  logic [OFFSET_W-1:0] byte_offset;
  logic [WORD_W-1:0]   pixel_word;
  logic [BYTES_W-1:0]  pixel_bytes;

  modport source (output valid, write_enable, byte_offset, pixel_word, pixel_bytes,
                  input ready);
  modport sink   (input valid, write_enable, byte_offset, pixel_word, pixel_bytes,
                  output ready);
endinterface

@@ hw/rtl/opfw_pix.sv @@
// pixel path: source decode with luminance products, then swap and packing
// depends on opfw_pkg; stage enables come from the top level
module opfw_pix
  import opfw_pkg::*;
(
  input  logic              clk,
  input  cfg_t              cfg,
  input  adv_t              adv,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [2:0]        bit_index,
  output logic [WORD_W-1:0] word
);

  logic        alpha8;
  logic        pick_bit;
  logic        black;
  logic [7:0]  gray;
  logic [7:0]  r_next, g_next, b_next, a_next;

  logic [7:0]  r1, g1, b1, a1;
  logic        use_lum;
  logic [15:0] pr, pg, pb;

  logic [16:0] lum_sum;
  logic [7:0]  a2;
  logic [7:0]  rs, bs;

  assign alpha8 = (cfg.out_format == FMT_ALPHA8);

  // msb-first picks bit 7 - index
  assign pick_bit = cfg.source_kind[0] ? byte0[~bit_index] : byte0[bit_index];
  assign black    = cfg.source_kind[1] ? pick_bit : !pick_bit;
  assign gray     = (cfg.source_kind == KIND_GRAY_INV) ? (SAMPLE_MAX - byte0) : byte0;

  always_comb begin
    r_next = byte0;
    g_next = byte1;
    b_next = byte2;
    a_next = SAMPLE_MAX;
    case (cfg.source_kind)
      KIND_GRAY, KIND_GRAY_INV: begin
        r_next = gray;
        g_next = gray;
        b_next = gray;
        a_next = alpha8 ? gray : SAMPLE_MAX;
      end
      KIND_RGB: begin
        a_next = SAMPLE_MAX;
      end
      KIND_RGBA: begin
        a_next = byte3;
      end
      default: begin
        // bilevel
        r_next = (black || alpha8) ? 8'd0 : SAMPLE_MAX;
        g_next = r_next;
        b_next = r_next;
        a_next = (alpha8 && !black) ? 8'd0 : SAMPLE_MAX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      r1      <= r_next;
      g1      <= g_next;
      b1      <= b_next;
      a1      <= a_next;
      use_lum <= alpha8 && (cfg.source_kind == KIND_RGB);
      pr      <= 16'(byte0) * 16'(LUM_R);
      pg      <= 16'(byte1) * 16'(LUM_G);
      pb      <= 16'(byte2) * 16'(LUM_B);
    end
  end

  assign lum_sum = 17'(pr) + 17'(pg) + 17'(pb);
  assign a2      = use_lum ? lum_sum[15:8] : a1;
  assign rs      = cfg.swap ? b1 : r1;
  assign bs      = cfg.swap ? r1 : b1;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      case (cfg.out_format)
        FMT_ALPHA8: word <= {24'd0, a2};
        FMT_RGB565: word <= {16'd0, rs[7:3], g1[7:2], bs[7:3]};
        default:    word <= {a2, bs, g1, rs};
      endcase
    end
  end

endmodule

@@ hw/rtl/opfw_map.sv @@
// coordinate path: orientation mapping, then bounds test and offset products
// depends on opfw_pkg; stage enables come from the top level
module opfw_map
  import opfw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)(
  input  logic                  clk,
  input  cfg_t                  cfg,
  input  adv_t                  adv,
  input  logic [COORD_BITS-1:0] col,
  input  logic [COORD_BITS-1:0] line,
  output logic                  in_bounds,
  output logic [OFFSET_W-1:0]   row_off,
  output logic [COL_OFF_W-1:0]  col_off
);

  logic [3:0]              ori;
  logic                    dims_swap;
  logic signed [MAP_W-1:0] lx, ly, w, h, xr, yr;
  logic signed [MAP_W-1:0] ox_next, oy_next;

  logic signed [MAP_W-1:0] ox, oy;
  logic [DIM_W-1:0]        bw, bh;

  // flip-only mode folds the transposing codes onto the plain flips
  always_comb begin
    ori = cfg.orientation;
    if (!cfg.honour && cfg.orientation >= ORI_LEFT_TOP &&
        cfg.orientation <= ORI_LEFT_BOTTOM) begin
      ori = cfg.orientation - ORI_FLIP_FOLD;
    end
  end

  assign dims_swap = cfg.honour && (cfg.orientation > ORI_BOTTOM_LEFT);

  assign lx = $signed(MAP_W'(col));
  assign ly = $signed(MAP_W'(line));
  assign w  = $signed(MAP_W'(cfg.width));
  assign h  = $signed(MAP_W'(cfg.height));
  assign xr = w - MAP_W'(1) - lx;
  assign yr = h - MAP_W'(1) - ly;

  always_comb begin
    case (ori)
      ORI_TOP_RIGHT:    begin ox_next = xr; oy_next = ly; end
      ORI_BOTTOM_RIGHT: begin ox_next = xr; oy_next = yr; end
      ORI_BOTTOM_LEFT:  begin ox_next = lx; oy_next = yr; end
      ORI_LEFT_TOP:     begin ox_next = ly; oy_next = lx; end
      ORI_RIGHT_TOP:    begin ox_next = yr; oy_next = lx; end
      ORI_RIGHT_BOTTOM: begin ox_next = yr; oy_next = xr; end
      ORI_LEFT_BOTTOM:  begin ox_next = ly; oy_next = xr; end
      default:          begin ox_next = lx; oy_next = ly; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ox <= ox_next;
      oy <= oy_next;
      bw <= dims_swap ? cfg.height : cfg.width;
      bh <= dims_swap ? cfg.width : cfg.height;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      in_bounds <= !ox[MAP_W-1] && !oy[MAP_W-1] &&
                   (ox < $signed(MAP_W'(bw))) && (oy < $signed(MAP_W'(bh)));
      row_off   <= OFFSET_W'(oy[DIM_W-1:0]) * OFFSET_W'(cfg.stride);
      col_off   <= COL_OFF_W'(ox[DIM_W-1:0]) << fmt_shift(cfg.out_format);
    end
  end

endmodule

@@ hw/rtl/oriented_pixel_format_writer.sv @@
// the accepted request passes stages 1 and 2, then reaches the output register in stage 3
// throughput: one pixel per cycle; each of the three stages holds while its successor is full
// stage 1 maps the coordinate and forms luminance products, stage 2 tests bounds and
// multiplies row by stride, stage 3 adds the offsets and registers the result
// reset (rst, synchronous) empties the pipeline and loads the register defaults
// depends on opfw_pkg, opfw_in_if, opfw_out_if, opfw_pix, opfw_map
module oriented_pixel_format_writer
  import opfw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  opfw_in_if.sink                pix_in,
  opfw_out_if.source             pix_out
);

  cfg_t cfg;
  adv_t adv;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic                 in_bounds;
  logic [OFFSET_W-1:0]  row_off;
  logic [COL_OFF_W-1:0] col_off;
  logic [WORD_W-1:0]    word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_format  <= RST_OUT_FORMAT;
      cfg.source_kind <= RST_SOURCE_KIND;
      cfg.orientation <= RST_ORIENTATION;
      cfg.honour      <= 1'b0;
      cfg.swap        <= 1'b0;
      cfg.width       <= RST_DIM;
      cfg.height      <= RST_DIM;
      cfg.stride      <= RST_STRIDE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OUT_FORMAT:  cfg.out_format  <= cfg_data[1:0];
        REG_SOURCE_KIND: cfg.source_kind <= cfg_data[2:0];
        REG_ORIENTATION: cfg.orientation <= cfg_data[3:0];
        REG_HONOUR:      cfg.honour      <= cfg_data[0];
        REG_SWAP:        cfg.swap        <= cfg_data[0];
        REG_WIDTH:       cfg.width       <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:      cfg.height      <= cfg_data[DIM_W-1:0];
        REG_STRIDE:      cfg.stride      <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage takes new data when empty or when its contents move on
  assign rdy3   = !v3 || pix_out.ready;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;

  assign pix_in.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  opfw_map #(
    .COORD_BITS (COORD_BITS)
  ) u_map (
    .clk       (clk),
    .cfg       (cfg),
    .adv       (adv),
    .col       (pix_in.col),
    .line      (pix_in.line),
    .in_bounds (in_bounds),
    .row_off   (row_off),
    .col_off   (col_off)
  );

  opfw_pix u_pix (
    .clk       (clk),
    .cfg       (cfg),
    .adv       (adv),
    .byte0     (pix_in.byte0),
    .byte1     (pix_in.byte1),
    .byte2     (pix_in.byte2),
    .byte3     (pix_in.byte3),
    .bit_index (pix_in.bit_index),
    .word      (word)
  );

  // output register; pixels outside the destination carry zero offset and word
  always_ff @(posedge clk) begin
    if (rdy3) begin
      pix_out.write_enable <= in_bounds;
      pix_out.byte_offset  <= in_bounds ? (row_off + OFFSET_W'(col_off)) : '0;
      pix_out.pixel_word   <= in_bounds ? word : '0;
      pix_out.pixel_bytes  <= fmt_bytes(cfg.out_format);
    end
  end

  assign pix_out.valid = v3;

  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    pix_out.ready |-> pix_in.ready)
    else $error("input stalled while output is free");

  a_empty_after_reset : assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !pix_out.valid)
    else $error("pipeline not empty after reset");

  a_outside_zero : assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.write_enable) |->
      (pix_out.byte_offset == '0 && pix_out.pixel_word == '0))
    else $error("unwritten pixel carries data");

  a_bytes_legal : assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> $onehot(pix_out.pixel_bytes))
    else $error("pixel size not 1, 2 or 4");

  a_stage_fill : assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !pix_out.ready) |=> (v1 && v2 && v3))
    else $error("full pipeline lost an item under stall");

endmodule
